// File: src/lzfbd_pkg.sv
// Shared types and constants for the LZSS flag-byte decompressor.
// Used by the controller, the datapath and the top level; no dependencies.
package lzfbd_pkg;

    // Field and store widths.
    localparam int WIN_AW    = 12;   // history window address bits (4096 bytes)
    localparam int SIZE_W    = 24;   // byte counter and raw size width
    localparam int COUNT_W   = 5;    // match length, at most 18
    localparam int MIN_MATCH = 3;

    // Register map of the APB port.
    localparam int          PADDR_W      = 2;
    localparam logic [1:0]  REG_RAW_SIZE = 2'd0;
    localparam logic [23:0] RAW_SIZE_RST = 24'd1;

    // Result error codes.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIST = 2'd1;
    localparam logic [1:0] ERR_SIZE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_READ,
        ST_EMIT
    } state_t;

    // What the byte held in the datapath asks for.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_LIT,
        KIND_ERR_DIST,
        KIND_ERR_SIZE,
        KIND_MATCH
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic decode;
        logic put_single;
        logic rd_issue;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  copy_last;
        logic  out_free;
        logic  halted;
    } dp_status_t;

endpackage

// File: src/lzfbd_ctrl.sv
// Controller state machine of the LZSS flag-byte decompressor.
// Depends on lzfbd_pkg; drives the datapath with commands only.
module lzfbd_ctrl import lzfbd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                case (status.kind)
                    KIND_LIT, KIND_ERR_DIST, KIND_ERR_SIZE: state_next = ST_PUT;
                    KIND_MATCH:                             state_next = ST_READ;
                    default:                                state_next = ST_IDLE;
                endcase
            end
            ST_PUT: begin
                // A literal or an error result waits for a free output register.
                if (status.out_free) begin
                    cmd.put_single = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.copy_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/lzfbd_dpath.sv
// Datapath of the LZSS flag-byte decompressor: token parsing, checks,
// history window memory and the output register. Depends on lzfbd_pkg.
module lzfbd_dpath import lzfbd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  ctrl_cmd_t     cmd,
    output dp_status_t    status,
    input  logic          cfg_we,
    input  logic [23:0]   cfg_wdata,
    output logic [23:0]   raw_size,
    input  logic [7:0]    s_in_byte,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_run_last,
    output logic          m_stream_done,
    output logic [1:0]    m_error_code
);

    // History window.
    logic [7:0] win_mem [2**WIN_AW];

    logic [SIZE_W-1:0]  raw_size_reg;
    logic [SIZE_W-1:0]  bw_reg;
    logic [7:0]         flag_bits_reg;
    logic [3:0]         flag_left_reg;
    logic               phase_reg;
    logic [7:0]         first_reg;
    logic               halted_reg;
    logic [7:0]         in_byte_reg;
    logic [1:0]         pend_err_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [WIN_AW-1:0]  dist_reg;
    logic [7:0]         rdata_reg;

    logic               m_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               run_last_reg;
    logic               done_reg;
    logic [1:0]         err_reg;

    logic [WIN_AW-1:0]  match_dist;
    logic [COUNT_W-1:0] count;
    logic               dist_bad;
    logic               size_bad;
    logic               lit_full;
    kind_t              kind;
    logic [SIZE_W-1:0]  bw_inc;
    logic               done_hit;
    logic               out_free;
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic [WIN_AW-1:0]  rd_addr;

    // Token decode of the held byte against the parser state.
    assign match_dist = {first_reg[7:4], in_byte_reg};
    assign count      = {1'b0, first_reg[3:0]} + COUNT_W'(MIN_MATCH);
    assign dist_bad   = (match_dist == '0) ||
                        ({{(SIZE_W-WIN_AW){1'b0}}, match_dist} > bw_reg);
    assign size_bad = ({1'b0, bw_reg} + (SIZE_W+1)'(count)) > {1'b0, raw_size_reg};
    assign lit_full = (bw_reg >= raw_size_reg);

    always_comb begin
        kind = KIND_NONE;
        if (!halted_reg) begin
            if (!phase_reg) begin
                if (flag_left_reg != 4'd0 && flag_bits_reg[7]) begin
                    kind = lit_full ? KIND_ERR_SIZE : KIND_LIT;
                end
            end else if (dist_bad) begin
                kind = KIND_ERR_DIST;
            end else if (size_bad) begin
                kind = KIND_ERR_SIZE;
            end else begin
                kind = KIND_MATCH;
            end
        end
    end

    assign bw_inc   = bw_reg + SIZE_W'(1);
    assign done_hit = (bw_inc == raw_size_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign status.kind      = kind;
    assign status.copy_last = (count_reg == COUNT_W'(1));
    assign status.out_free  = out_free;
    assign status.halted    = halted_reg;

    // Input holding register and match operands.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_byte_reg <= s_in_byte;
        end
        if (cmd.decode) begin
            count_reg <= count;
            dist_reg  <= match_dist;
            case (kind)
                KIND_ERR_DIST: pend_err_reg <= ERR_DIST;
                KIND_ERR_SIZE: pend_err_reg <= ERR_SIZE;
                default:       pend_err_reg <= ERR_NONE;
            endcase
        end else if (cmd.emit) begin
            count_reg <= count_reg - COUNT_W'(1);
        end
    end

    // Parser state, byte count and halt flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_size_reg  <= RAW_SIZE_RST;
            bw_reg        <= '0;
            flag_bits_reg <= '0;
            flag_left_reg <= '0;
            phase_reg     <= 1'b0;
            first_reg     <= '0;
            halted_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                raw_size_reg <= cfg_wdata;
            end
            if (cmd.decode && !halted_reg) begin
                if (!phase_reg) begin
                    if (flag_left_reg == 4'd0) begin
                        flag_bits_reg <= in_byte_reg;
                        flag_left_reg <= 4'd8;
                    end else begin
                        flag_bits_reg <= {flag_bits_reg[6:0], 1'b0};
                        flag_left_reg <= flag_left_reg - 4'd1;
                        if (!flag_bits_reg[7]) begin
                            first_reg <= in_byte_reg;
                            phase_reg <= 1'b1;
                        end
                    end
                end else begin
                    phase_reg <= 1'b0;
                end
            end
            if (cmd.put_single) begin
                if (pend_err_reg != ERR_NONE) begin
                    halted_reg <= 1'b1;
                end else begin
                    bw_reg <= bw_inc;
                    if (done_hit) begin
                        halted_reg <= 1'b1;
                    end
                end
            end
            if (cmd.emit) begin
                bw_reg <= bw_inc;
                if (done_hit) begin
                    halted_reg <= 1'b1;
                end
            end
        end
    end

    // Window write: literals and copied bytes are appended at the byte count.
    assign mem_we    = (cmd.put_single && pend_err_reg == ERR_NONE) || cmd.emit;
    assign mem_wdata = cmd.emit ? rdata_reg : in_byte_reg;
    assign rd_addr   = bw_reg[WIN_AW-1:0] - dist_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[bw_reg[WIN_AW-1:0]] <= mem_wdata;
        end
    end

    // Window read, registered in the read state ahead of the matching emit.
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rdata_reg <= win_mem[rd_addr];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.put_single || cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_single) begin
            out_byte_reg <= (pend_err_reg == ERR_NONE) ? in_byte_reg : 8'd0;
            run_last_reg <= 1'b1;
            done_reg     <= (pend_err_reg == ERR_NONE) && done_hit;
            err_reg      <= pend_err_reg;
        end else if (cmd.emit) begin
            out_byte_reg <= rdata_reg;
            run_last_reg <= (count_reg == COUNT_W'(1));
            done_reg     <= done_hit;
            err_reg      <= ERR_NONE;
        end
    end

    assign raw_size      = raw_size_reg;
    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_run_last    = run_last_reg;
    assign m_stream_done = done_reg;
    assign m_error_code  = err_reg;

endmodule

// File: src/lzss_flag_byte_decompressor.sv
// Top level of the LZSS flag-byte decompressor: APB register port,
// controller and datapath. Depends on lzfbd_pkg, lzfbd_ctrl and lzfbd_dpath.
//
//   Channel  Ports                                         Direction
//   config   psel penable pwrite paddr pwdata prdata pready APB slave
//   input    s_valid s_ready s_in_byte                     packed bytes in
//   result   m_valid m_ready m_out_byte m_run_last
//            m_stream_done m_error_code                    decoded bytes out
//
// A flag byte or a first match byte passes the idle and decode states; a literal
// or an error also passes the put state. A second match byte adds a read and an emit
// step per copied byte: the registered window read, then the write-back and output load.
// Reset is synchronous and active low; the window is not cleared.
// A result waiting on m_ready stalls only the step that loads the next one.
module lzss_flag_byte_decompressor import lzfbd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_run_last,
    output logic               m_stream_done,
    output logic [1:0]         m_error_code
);

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic        cfg_we;
    logic [23:0] raw_size;

    // Register access.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_RAW_SIZE);
    assign prdata = (paddr == REG_RAW_SIZE) ? {8'd0, raw_size} : 32'd0;

    lzfbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lzfbd_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (pwdata[23:0]),
        .raw_size      (raw_size),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_stream_done (m_stream_done),
        .m_error_code  (m_error_code)
    );

    // An error result always closes its run.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> m_run_last)
        else $error("error result without run_last");

    // The stream can only complete on the last byte of a run.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_done) |-> m_run_last)
        else $error("stream_done before the end of a run");

    // An error or a completed stream leaves the parser halted.
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_stream_done || m_error_code != ERR_NONE)) |-> status.halted)
        else $error("terminal result without halt");

    // Nothing is loaded into the output register while it still holds an item.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put_single || cmd.emit) |-> (!m_valid || m_ready))
        else $error("output register overwritten");

endmodule
